@@ hw/rtl/mlfr_pkg.sv @@
// shared types and constants for the led fade ramp controller
`default_nettype none
package mlfr_pkg;

  localparam int DAC_BITS        = 12;
  localparam int FRAC_BITS       = 16;
  localparam int LEVEL_W         = DAC_BITS + FRAC_BITS;
  localparam int PCT_W           = 10;
  localparam int DUR_W           = 14;
  localparam int CFG_IDX_W       = 2;
  localparam int CHANNELS_DEF    = 6;
  localparam int TICK_MS_DEF     = 10;
  localparam int PERCENT_MAX_DEF = 1000;
  localparam int DUR_MIN         = 50;
  localparam int DUR_MAX         = 10000;
  localparam int DUR_RESET       = 1000;

  typedef enum logic [2:0] {
    OP_SET      = 3'd0,
    OP_ON       = 3'd1,
    OP_OFF      = 3'd2,
    OP_FADE_ON  = 3'd3,
    OP_FADE_OFF = 3'd4,
    OP_TICK     = 3'd5
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FADE_DURATION = 2'd0,
    CFG_MIN_COUNT     = 2'd1,
    CFG_MAX_COUNT     = 2'd2
  } cfg_idx_t;

  localparam logic [1:0] PWM_NONE = 2'd0;
  localparam logic [1:0] PWM_FULL = 2'd1;
  localparam logic       ST_OK    = 1'b0;
  localparam logic       ST_RANGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_MAP,
    S_TOT,
    S_SCAN,
    S_STEP,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       channel;
    logic [PCT_W-1:0] percent;
  } in_t;

  typedef struct packed {
    logic [2:0]          chan_out;
    logic                dac_write;
    logic [DAC_BITS-1:0] dac_count;
    logic [1:0]          pwm_action;
    logic                enabled_now;
    logic                fading_now;
    logic                status;
    logic                last;
  } out_t;

  typedef struct packed {
    logic                enabled;
    logic                fading;
    logic                off_after_fade;
    logic [LEVEL_W-1:0]  level_now;
    logic [LEVEL_W-1:0]  level_start;
    logic [DAC_BITS-1:0] level_target;
    logic [PCT_W-1:0]    setpoint;
  } entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/mlfr_div.sv @@
// restoring divider, one quotient bit per cycle
`default_nettype none
module mlfr_div #(
  parameter int DW = 28,
  parameter int VW = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);
  localparam int CNT_W = $clog2(DW + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VW-1:0]    rem_r, rem_nxt;
  logic [DW-1:0]    quo_r, quo_nxt;
  logic [VW-1:0]    dvs_r, dvs_nxt;
  logic [VW:0]      sh;
  logic [VW:0]      diff;
  logic             ge;

  always_comb begin
    sh   = {rem_r, quo_r[DW-1]};
    diff = sh - {1'b0, dvs_r};
    ge   = (sh >= {1'b0, dvs_r});
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(DW);
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? diff[VW-1:0] : sh[VW-1:0];
      quo_nxt = {quo_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ hw/rtl/multichannel_led_fade_ramp_core.sv @@
// top level of the multichannel led fade ramp controller
//
// A command word is taken when start is high and busy is low; busy falls in the cycle in
// which the last result of that word is on the result ports. Results appear as one-cycle
// strobes on out_valid and cannot be held off, so the receiver must take each one as it
// comes. Channel state sits in one synchronous memory that is read, updated and written
// back per channel. Off, fade off and fade on of a channel already on hold busy for 1
// cycle; set percent, on and fade on otherwise hold it for 2, the second scaling the
// setpoint by a constant reciprocal multiply. A tick holds busy for 1 cycle to form the
// step count, then 1 cycle for each idle channel and 30 for each fading channel, set by
// the shared one-bit-per-cycle 28-bit divider that forms the step, plus 1 to put out the
// final result. An out-of-range channel or an unused op code costs no busy cycles.
`default_nettype none
module multichannel_led_fade_ramp_core #(
  parameter int CHANNELS    = mlfr_pkg::CHANNELS_DEF,
  parameter int TICK_MS     = mlfr_pkg::TICK_MS_DEF,
  parameter int PERCENT_MAX = mlfr_pkg::PERCENT_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire mlfr_pkg::in_t                  in_data,
  output logic                                out_valid,
  output mlfr_pkg::out_t                      out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [mlfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mlfr_pkg::DUR_W-1:0]     cfg_data
);
  import mlfr_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // reciprocals for the two constant divisions, exact over the operand ranges used
  localparam int MAP_SH = 32;
  localparam int TOT_SH = 24;
  localparam logic [25:0] MAP_K =
    26'(((64'd1 << MAP_SH) + 64'(PERCENT_MAX) - 64'd1) / 64'(PERCENT_MAX));
  localparam logic [24:0] TOT_K =
    25'(((64'd1 << TOT_SH) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  state_t state_r, state_nxt;

  // configuration
  logic [DUR_W-1:0]    fade_r;
  logic [DAC_BITS-1:0] min_r, max_r;

  // sequencer registers
  in_t              cmd_r, cmd_nxt;
  logic [CH_W-1:0]  idx_r, idx_nxt;
  logic [DUR_W-1:0] total_r, total_nxt;
  out_t             pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [21:0]      prod_r, prod_nxt;

  // channel memory
  entry_t          mem [CHANNELS];
  entry_t          rdata_r;
  logic            rvalid_r;
  logic [CHANNELS-1:0] valid_r;
  logic            mem_re, mem_we;
  logic [CH_W-1:0] mem_raddr, mem_waddr;
  entry_t          mem_wdata;
  entry_t          e;

  // divider
  logic                div_start, div_done;
  logic [LEVEL_W-1:0]  div_a, div_q;
  logic [DUR_W-1:0]    div_b;

  // command datapath
  logic [3:0]          in_ext, idx_ext;
  logic [CH_W-1:0]     in_idx;
  logic                in_range;
  logic [DAC_BITS-1:0] span;
  logic [PCT_W-1:0]    pc;
  logic [21:0]         prod;
  logic [47:0]         map_full;
  logic [39:0]         tot_full;
  logic [DUR_W-1:0]    tot_q;
  logic [DAC_BITS-1:0] raw;
  logic                need_map;
  entry_t              c_ent;
  out_t                c_res;
  out_t                err_res;

  // tick datapath
  logic [LEVEL_W-1:0]  tgt, mag;
  logic                neg;
  logic [LEVEL_W+1:0]  now_w;
  logic                arrive;
  entry_t              t_ent;
  out_t                t_res;
  logic                last_ch;

  mlfr_div #(
    .DW(LEVEL_W),
    .VW(DUR_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= DUR_W'(DUR_RESET);
      min_r  <= '0;
      max_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FADE_DURATION: begin
          if (cfg_data < DUR_W'(DUR_MIN)) begin
            fade_r <= DUR_W'(DUR_MIN);
          end else if (cfg_data > DUR_W'(DUR_MAX)) begin
            fade_r <= DUR_W'(DUR_MAX);
          end else begin
            fade_r <= cfg_data;
          end
        end
        CFG_MIN_COUNT: min_r <= cfg_data[DAC_BITS-1:0];
        CFG_MAX_COUNT: max_r <= cfg_data[DAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // channel memory, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r  <= mem[mem_raddr];
      rvalid_r <= valid_r[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[mem_waddr] <= 1'b1;
    end
  end

  assign e = rvalid_r ? rdata_r : '0;

  // command decode
  always_comb begin
    in_ext   = {1'b0, in_data.channel};
    in_idx   = in_ext[CH_W-1:0];
    in_range = (int'(in_ext) < CHANNELS);
    idx_ext  = 4'(idx_r);
    last_ch  = (idx_r == CH_W'(CHANNELS - 1));
    tot_full = 40'(fade_r) * 40'(TOT_K);
    tot_q    = tot_full[TOT_SH +: DUR_W];
    err_res           = '0;
    err_res.chan_out  = in_data.channel;
    err_res.status    = ST_RANGE;
    err_res.last      = 1'b1;
  end

  // setpoint to count mapping and command update
  always_comb begin
    span = (max_r >= min_r) ? (max_r - min_r) : '0;
    if (cmd_r.op == OP_SET) begin
      pc = (cmd_r.percent > PCT_W'(PERCENT_MAX)) ? PCT_W'(PERCENT_MAX) : cmd_r.percent;
    end else begin
      pc = e.setpoint;
    end
    prod     = 22'(span) * 22'(pc);
    map_full = 48'(prod_r) * 48'(MAP_K);
    raw      = min_r + map_full[MAP_SH +: DAC_BITS];
    need_map = (cmd_r.op == OP_SET) || (cmd_r.op == OP_ON) ||
               ((cmd_r.op == OP_FADE_ON) && !(e.enabled && !e.fading));

    c_ent          = e;
    c_res          = '0;
    c_res.chan_out = cmd_r.channel;
    c_res.status   = ST_OK;
    c_res.last     = 1'b1;
    case (cmd_r.op)
      OP_SET: begin
        c_ent.setpoint = pc;
        if (e.enabled) begin
          c_res.dac_write  = 1'b1;
          c_res.dac_count  = raw;
          c_res.pwm_action = PWM_FULL;
        end
      end
      OP_ON: begin
        c_ent.enabled        = 1'b1;
        c_ent.fading         = 1'b0;
        c_ent.off_after_fade = 1'b0;
        c_ent.level_now      = {raw, FRAC_BITS'(0)};
        c_res.dac_write      = 1'b1;
        c_res.dac_count      = raw;
        c_res.pwm_action     = PWM_FULL;
      end
      OP_OFF: begin
        c_ent.enabled        = 1'b0;
        c_ent.fading         = 1'b0;
        c_ent.off_after_fade = 1'b0;
        c_ent.level_now      = '0;
        c_res.dac_write      = 1'b1;
      end
      OP_FADE_ON: begin
        c_res.pwm_action = PWM_FULL;
        if (!(e.enabled && !e.fading)) begin
          c_ent.enabled = 1'b1;
          if (!e.fading) begin
            c_ent.level_now = '0;
            c_res.dac_write = 1'b1;
          end
          c_ent.level_start    = c_ent.level_now;
          c_ent.level_target   = raw;
          c_ent.fading         = 1'b1;
          c_ent.off_after_fade = 1'b0;
        end
      end
      OP_FADE_OFF: begin
        c_ent.level_start    = e.level_now;
        c_ent.level_target   = '0;
        c_ent.fading         = 1'b1;
        c_ent.off_after_fade = 1'b1;
      end
      default: ;
    endcase
    c_res.enabled_now = c_ent.enabled;
    c_res.fading_now  = c_ent.fading;
  end

  // one fade step of the channel under the tick
  always_comb begin
    tgt   = {e.level_target, FRAC_BITS'(0)};
    neg   = (tgt < e.level_start);
    mag   = neg ? (e.level_start - tgt) : (tgt - e.level_start);
    now_w = neg ? ({2'b00, e.level_now} - {2'b00, div_q})
                : ({2'b00, e.level_now} + {2'b00, div_q});
    // negative sum means it has gone past zero, hence past the target
    arrive = (div_q == '0) ||
             (!neg && (now_w >= {2'b00, tgt})) ||
             (neg && (now_w[LEVEL_W+1] || (now_w <= {2'b00, tgt})));
    t_ent = e;
    if (arrive) begin
      t_ent.level_now = tgt;
      t_ent.fading    = 1'b0;
      if (e.off_after_fade) begin
        t_ent.enabled        = 1'b0;
        t_ent.off_after_fade = 1'b0;
      end
    end else begin
      t_ent.level_now = now_w[LEVEL_W-1:0];
    end
    t_res             = '0;
    t_res.chan_out    = idx_ext[2:0];
    t_res.dac_write   = 1'b1;
    t_res.dac_count   = t_ent.level_now[LEVEL_W-1:FRAC_BITS];
    t_res.pwm_action  = PWM_NONE;
    t_res.enabled_now = t_ent.enabled;
    t_res.fading_now  = t_ent.fading;
    t_res.status      = ST_OK;
    t_res.last        = 1'b0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_data.op == OP_TICK) begin
            state_nxt = S_TOT;
          end else if ((in_data.op inside {[OP_SET:OP_FADE_OFF]}) && in_range) begin
            state_nxt = S_CMD;
          end
        end
      end
      S_CMD:  state_nxt = need_map ? S_MAP : S_IDLE;
      S_MAP:  state_nxt = S_IDLE;
      S_TOT:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (e.fading) begin
          state_nxt = S_STEP;
        end else if (last_ch) begin
          state_nxt = S_FLUSH;
        end
      end
      S_STEP: begin
        if (div_done) begin
          state_nxt = last_ch ? S_FLUSH : S_SCAN;
        end
      end
      S_FLUSH: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_nxt       = out_r;
    prod_nxt      = prod_r;
    out_valid_nxt = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = c_ent;
    div_start     = 1'b0;
    div_a         = mag;
    div_b         = total_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_data;
          idx_nxt = in_idx;
          if (in_data.op inside {[OP_SET:OP_FADE_OFF]}) begin
            if (in_range) begin
              mem_re    = 1'b1;
              mem_raddr = in_idx;
            end else begin
              out_valid_nxt = 1'b1;
              out_nxt       = err_res;
            end
          end
        end
      end
      S_CMD: begin
        if (need_map) begin
          prod_nxt = prod;
        end else begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_nxt       = c_res;
        end
      end
      S_MAP: begin
        mem_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_nxt       = c_res;
      end
      S_TOT: begin
        total_nxt = (tot_q == '0) ? DUR_W'(1) : tot_q;
        idx_nxt   = '0;
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_SCAN: begin
        if (e.fading) begin
          div_start = 1'b1;
        end else if (!last_ch) begin
          idx_nxt   = idx_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = idx_r + 1'b1;
        end
      end
      S_STEP: begin
        if (div_done) begin
          mem_we    = 1'b1;
          mem_wdata = t_ent;
          // hold each word back until it is known whether another follows
          out_valid_nxt = pend_v_r;
          out_nxt       = pend_r;
          pend_nxt      = t_res;
          pend_v_nxt    = 1'b1;
          if (!last_ch) begin
            idx_nxt   = idx_r + 1'b1;
            mem_re    = 1'b1;
            mem_raddr = idx_r + 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_nxt       = pend_r;
          out_nxt.last  = 1'b1;
        end
        pend_v_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    total_r <= total_nxt;
    pend_r  <= pend_nxt;
    out_r   <= out_nxt;
    prod_r  <= prod_nxt;
  end

endmodule
`default_nettype wire

@@ hw/rtl/mlfr_checker.sv @@
// port-level checks on the led fade ramp controller, bound to the top level
`default_nettype none
module mlfr_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           busy,
  input wire logic           out_valid,
  input wire mlfr_pkg::out_t out_data
);
  import mlfr_pkg::*;

  // a range error is always the only word of its command
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |-> out_data.last)
    else $error("range error word not marked last");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      !out_data.dac_write && !out_data.enabled_now && !out_data.fading_now &&
      (out_data.pwm_action == PWM_NONE))
    else $error("range error word carries channel data");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.dac_write |-> (out_data.dac_count == '0))
    else $error("dac count without a write");

  a_pwm_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.pwm_action == PWM_FULL) |-> out_data.enabled_now)
    else $error("pwm driven on a disabled channel");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("busy or strobe after reset");

endmodule

bind multichannel_led_fade_ramp_core mlfr_checker u_mlfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire

@@ dv/multichannel_led_fade_ramp_core_tb.sv @@
// self-checking testbench for the multichannel led fade ramp controller
module multichannel_led_fade_ramp_core_tb;
  import mlfr_pkg::*;

  localparam int NCH        = CHANNELS_DEF;
  localparam int TICK_LEN   = TICK_MS_DEF;
  localparam int PCT_FULL   = PERCENT_MAX_DEF;
  localparam int DRAIN_CYC  = 400;
  localparam int CYCLE_CAP  = 800000;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FADE_DURATION;
  logic [DUR_W-1:0] cfg_data = '0;

  multichannel_led_fade_ramp_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of configuration and channel state
  int unsigned dur_ms = DUR_RESET;
  int unsigned lo_count = 0;
  int unsigned hi_count = 4095;
  logic ch_on [NCH];
  logic ch_fading [NCH];
  logic ch_off_at_end [NCH];
  logic [LEVEL_W-1:0] ch_level [NCH];
  logic [LEVEL_W-1:0] ch_from [NCH];
  logic [DAC_BITS-1:0] ch_target [NCH];
  logic [PCT_W-1:0] ch_setpoint [NCH];

  in_t pending_words[$];
  out_t expected_writes[$];
  int gap_left = 0;
  bit no_gaps = 1'b0;
  bit failed = 1'b0;
  int unsigned cycles = 0;

  initial forever #5 clk = ~clk;

  function automatic logic [DAC_BITS-1:0] to_count(int unsigned p);
    int unsigned span;
    span = (hi_count >= lo_count) ? hi_count - lo_count : 0;
    if (p > PCT_FULL) p = PCT_FULL;
    return DAC_BITS'(lo_count + (span * p) / PCT_FULL);
  endfunction

  function automatic out_t make_result(int ch, logic wr, logic [DAC_BITS-1:0] val,
                                       logic [1:0] pwm, logic st, logic lst);
    out_t r;
    r.chan_out = 3'(ch);
    r.dac_write = wr;
    r.dac_count = val;
    r.pwm_action = pwm;
    r.enabled_now = (ch < NCH && st == ST_OK) ? ch_on[ch] : 1'b0;
    r.fading_now = (ch < NCH && st == ST_OK) ? ch_fading[ch] : 1'b0;
    r.status = st;
    r.last = lst;
    return r;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] v);
    case (idx)
      CFG_FADE_DURATION: dur_ms = (v < DUR_MIN) ? DUR_MIN : (v > DUR_MAX) ? DUR_MAX : v;
      CFG_MIN_COUNT:     lo_count = v[DAC_BITS-1:0];
      CFG_MAX_COUNT:     hi_count = v[DAC_BITS-1:0];
      default: ;
    endcase
  endfunction

  function automatic void predict_word(in_t w);
    int ch;
    int unsigned steps;
    longint tgt, diff, mag, q, stp, nxt;
    logic done;
    logic [DAC_BITS-1:0] raw;
    logic wr;
    int lastpos;
    ch = w.channel;
    if (w.op == OP_SPARE6 || w.op == OP_SPARE7) return;
    if (w.op == OP_TICK) begin
      steps = dur_ms / TICK_LEN;
      if (steps == 0) steps = 1;
      lastpos = -1;
      for (int c = 0; c < NCH; c++) begin
        if (!ch_fading[c]) continue;
        tgt = longint'(ch_target[c]) << FRAC_BITS;
        diff = tgt - longint'(ch_from[c]);
        mag = (diff < 0) ? -diff : diff;
        q = mag / steps;
        stp = (diff < 0) ? -q : q;
        nxt = longint'(ch_level[c]) + stp;
        done = (stp == 0) || (stp > 0 && nxt >= tgt) || (stp < 0 && nxt <= tgt);
        if (done) begin
          ch_level[c] = LEVEL_W'(tgt);
          ch_fading[c] = 1'b0;
          if (ch_off_at_end[c]) begin
            ch_on[c] = 1'b0;
            ch_off_at_end[c] = 1'b0;
          end
        end else begin
          ch_level[c] = LEVEL_W'(nxt);
        end
        expected_writes.push_back(make_result(c, 1'b1, ch_level[c][LEVEL_W-1:FRAC_BITS],
                                              PWM_NONE, ST_OK, 1'b0));
        lastpos = expected_writes.size() - 1;
      end
      if (lastpos >= 0) expected_writes[lastpos].last = 1'b1;
      return;
    end
    if (ch >= NCH) begin
      expected_writes.push_back(make_result(ch, 1'b0, '0, PWM_NONE, ST_RANGE, 1'b1));
      return;
    end
    case (w.op)
      OP_SET: begin
        ch_setpoint[ch] = (w.percent > PCT_FULL) ? PCT_W'(PCT_FULL) : w.percent;
        raw = to_count(ch_setpoint[ch]);
        if (ch_on[ch])
          expected_writes.push_back(make_result(ch, 1'b1, raw, PWM_FULL, ST_OK, 1'b1));
        else
          expected_writes.push_back(make_result(ch, 1'b0, '0, PWM_NONE, ST_OK, 1'b1));
      end
      OP_ON: begin
        raw = to_count(ch_setpoint[ch]);
        ch_on[ch] = 1'b1;
        ch_fading[ch] = 1'b0;
        ch_off_at_end[ch] = 1'b0;
        ch_level[ch] = {raw, 16'd0};
        expected_writes.push_back(make_result(ch, 1'b1, raw, PWM_FULL, ST_OK, 1'b1));
      end
      OP_OFF: begin
        ch_on[ch] = 1'b0;
        ch_fading[ch] = 1'b0;
        ch_off_at_end[ch] = 1'b0;
        ch_level[ch] = '0;
        expected_writes.push_back(make_result(ch, 1'b1, '0, PWM_NONE, ST_OK, 1'b1));
      end
      OP_FADE_ON: begin
        wr = 1'b0;
        if (!(ch_on[ch] && !ch_fading[ch])) begin
          ch_on[ch] = 1'b1;
          if (!ch_fading[ch]) begin
            ch_level[ch] = '0;
            wr = 1'b1;
          end
          ch_from[ch] = ch_level[ch];
          ch_target[ch] = to_count(ch_setpoint[ch]);
          ch_fading[ch] = 1'b1;
          ch_off_at_end[ch] = 1'b0;
        end
        expected_writes.push_back(make_result(ch, wr, '0, PWM_FULL, ST_OK, 1'b1));
      end
      default: begin
        ch_from[ch] = ch_level[ch];
        ch_target[ch] = '0;
        ch_fading[ch] = 1'b1;
        ch_off_at_end[ch] = 1'b1;
        expected_writes.push_back(make_result(ch, 1'b0, '0, PWM_NONE, ST_OK, 1'b1));
      end
    endcase
  endfunction

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) predict_word(in_data);
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_words.size() != 0) begin
          if (!no_gaps && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            gap_left <= $urandom_range(1, 16) - 1;
          end else begin
            start <= 1'b1;
            in_data <= pending_words.pop_front();
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      failed = 1'b1;
    end
  endtask

  // result monitor and watchdog
  always @(posedge clk) begin
    out_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("** multichannel_led_fade_ramp_core: FAILED **");
      $finish;
    end else if (rst_n && out_valid) begin
      if (expected_writes.size() == 0) begin
        $error("unexpected result word for channel %0d", out_data.chan_out);
        failed = 1'b1;
      end else begin
        e = expected_writes.pop_front();
        check_field("chan_out", e.chan_out, out_data.chan_out);
        check_field("dac_write", e.dac_write, out_data.dac_write);
        check_field("dac_count", e.dac_count, out_data.dac_count);
        check_field("pwm_action", e.pwm_action, out_data.pwm_action);
        check_field("enabled_now", e.enabled_now, out_data.enabled_now);
        check_field("fading_now", e.fading_now, out_data.fading_now);
        check_field("status", e.status, out_data.status);
        check_field("last", e.last, out_data.last);
      end
    end
  end

  task automatic add(logic [2:0] op, int ch, int pct);
    in_t w;
    w.op = op;
    w.channel = 3'(ch);
    w.percent = PCT_W'(pct);
    pending_words.push_back(w);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUR_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, v);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0 || start || expected_writes.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  // mostly well-formed fade sequences, the rest noise
  task automatic random_words(int n);
    int cnt;
    int c;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 7) begin
        c = $urandom_range(0, NCH - 1);
        add(OP_SET, c, $urandom_range(0, 1023));
        add($urandom_range(0, 3) == 0 ? OP_ON : OP_FADE_ON, c, $urandom);
        cnt += 2;
        repeat ($urandom_range(1, 7)) begin add(OP_TICK, $urandom, $urandom); cnt++; end
        if ($urandom_range(0, 2) != 0) begin add(OP_SET, c, $urandom); cnt++; end
        if ($urandom_range(0, 1) != 0) begin add(OP_FADE_OFF, c, $urandom); cnt++; end
        repeat ($urandom_range(0, 6)) begin add(OP_TICK, $urandom, $urandom); cnt++; end
      end else begin
        add(3'($urandom_range(0, 7)), $urandom_range(0, 7), $urandom_range(0, 1023));
        cnt++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NCH; i++) begin
      ch_on[i] = 1'b0; ch_fading[i] = 1'b0; ch_off_at_end[i] = 1'b0;
      ch_level[i] = '0; ch_from[i] = '0; ch_target[i] = '0; ch_setpoint[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset configuration
    add(OP_TICK, 0, 0);
    add(OP_SET, 0, 1023);
    add(OP_ON, 0, 0);
    add(OP_SET, 0, 0);
    add(OP_SET, 0, 500);
    add(OP_FADE_OFF, 0, 0);
    add(OP_FADE_ON, 1, 0);
    add(OP_FADE_OFF, 2, 0);
    add(OP_TICK, 7, 1023);
    add(OP_FADE_ON, 0, 0);
    add(OP_SET, 3, 1000);
    add(OP_ON, 3, 0);
    add(OP_FADE_ON, 3, 0);
    add(OP_TICK, 0, 0);
    add(OP_OFF, 5, 0);
    add(OP_SET, 6, 1023);
    add(OP_FADE_ON, 7, 0);
    add(OP_SPARE6, 0, 0);
    add(OP_SPARE7, 7, 1023);
    add(OP_OFF, 1, 0);
    add(OP_TICK, 0, 0);
    drain();

    write_reg(CFG_FADE_DURATION, 50);
    write_reg(CFG_MIN_COUNT, 0);
    write_reg(CFG_MAX_COUNT, 4095);
    random_words(100);
    drain();

    // saturating duration, inverted count range
    write_reg(CFG_FADE_DURATION, 14'h3FFF);
    write_reg(CFG_MIN_COUNT, 4095);
    write_reg(CFG_MAX_COUNT, 0);
    random_words(40);
    drain();

    write_reg(CFG_FADE_DURATION, 0);
    write_reg(CFG_MIN_COUNT, 100);
    write_reg(CFG_MAX_COUNT, 14'h3BB8);
    random_words(100);
    drain();

    no_gaps = 1'b1;
    write_reg(CFG_FADE_DURATION, 120);
    write_reg(CFG_MIN_COUNT, 1234);
    write_reg(CFG_MAX_COUNT, 1234);
    random_words(40);
    drain();
    write_reg(CFG_MIN_COUNT, 0);
    write_reg(CFG_MAX_COUNT, 4095);
    random_words(80);
    drain();

    if (!failed) begin
      $display("** multichannel_led_fade_ramp_core: PASSED **");
    end else begin
      $display("** multichannel_led_fade_ramp_core: FAILED **");
    end
    $finish;
  end

endmodule
